/* rtl/tfr_pkg.sv */
// Shared types and constants for the TLB with FIFO replacement.
`timescale 1ns / 1ps
`default_nettype none

package tfr_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int FRAME_BITS_DEF  = 8;

    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef struct packed {
        logic               command;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame_in;
        logic               readonly_in;
    } tfr_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic               readonly_out;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] change_count;
    } tfr_rsp_t;

endpackage

`default_nettype wire

/* rtl/tfr_fifo.sv */
// Replacement order queue: oldest entry index at the head, shifted on removal.
`timescale 1ns / 1ps
`default_nettype none

module tfr_fifo #(
    parameter int NUM_ENTRIES = tfr_pkg::NUM_ENTRIES_DEF,
    localparam int IW = $clog2(NUM_ENTRIES),
    localparam int LW = $clog2(NUM_ENTRIES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          update_en,
    input  logic          remove_en,
    input  logic [IW-1:0] value,
    output logic [IW-1:0] head,
    output logic          head_ok
);

    logic [IW-1:0]          order_reg  [NUM_ENTRIES];
    logic [IW-1:0]          order_next [NUM_ENTRIES];
    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          len_next;
    logic [LW-1:0]          len_mid;
    logic [NUM_ENTRIES-1:0] match;
    logic [NUM_ENTRIES-1:0] shift;
    logic                   removed;

    assign head    = order_reg[0];
    assign head_ok = (len_reg != '0) && (LW'(order_reg[0]) < LW'(NUM_ENTRIES));

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            match[k] = remove_en && (LW'(k) < len_reg) && (order_reg[k] == value);
        end
        // Every position at or above the first match moves down by one.
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            shift[k] = 1'b0;
            for (int j = 0; j <= k; j++)
            begin
                shift[k] = shift[k] | match[j];
            end
        end
        removed = |match;
        len_mid = len_reg - LW'(removed);

        order_next = order_reg;
        for (int k = 0; k < NUM_ENTRIES - 1; k++)
        begin
            if (shift[k])
            begin
                order_next[k] = order_reg[k + 1];
            end
        end
        len_next = len_mid;
        if (len_mid < LW'(NUM_ENTRIES))
        begin
            order_next[len_mid[IW-1:0]] = value;
            len_next = len_mid + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (update_en)
        begin
            order_reg <= order_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (update_en)
        begin
            len_reg <= len_next;
        end
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(NUM_ENTRIES))
        else $error("replacement queue longer than the entry count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        update_en && !remove_en && (len_reg < LW'(NUM_ENTRIES))
        |=> len_reg == $past(len_reg) + LW'(1))
        else $error("append to a free slot did not grow the queue");
`endif

endmodule

`default_nettype wire

/* rtl/tfr_cam.sv */
// Entry store with parallel page and frame compare and victim selection.
`timescale 1ns / 1ps
`default_nettype none

module tfr_cam #(
    parameter int NUM_ENTRIES = tfr_pkg::NUM_ENTRIES_DEF,
    parameter int PAGE_BITS   = tfr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS  = tfr_pkg::FRAME_BITS_DEF,
    localparam int IW = $clog2(NUM_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfr_pkg::tfr_req_t     req,
    input  logic                  write_en,
    input  logic [IW-1:0]         head,
    input  logic                  head_ok,
    output logic                  hit,
    output logic [FRAME_BITS-1:0] hit_frame,
    output logic                  hit_readonly,
    output logic [IW-1:0]         hit_index,
    output logic [IW-1:0]         add_index,
    output logic                  remove_en
);

    import tfr_pkg::*;

    localparam int PC = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int FC = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;

    logic                   valid_reg    [NUM_ENTRIES];
    logic [PAGE_BITS-1:0]   page_reg     [NUM_ENTRIES];
    logic [FRAME_BITS-1:0]  frame_reg    [NUM_ENTRIES];
    logic                   readonly_reg [NUM_ENTRIES];

    logic [PAGE_BITS-1:0]   pg;
    logic [FRAME_BITS-1:0]  fr;
    logic [NUM_ENTRIES-1:0] page_match;
    logic [NUM_ENTRIES-1:0] frame_match;
    logic [NUM_ENTRIES-1:0] free_vec;
    logic [NUM_ENTRIES-1:0] page_oh;
    logic [NUM_ENTRIES-1:0] frame_oh;
    logic [NUM_ENTRIES-1:0] free_oh;
    logic [IW-1:0]          frame_index;
    logic [IW-1:0]          free_index;

    always_comb
    begin
        pg = '0;
        pg[PC-1:0] = req.page[PC-1:0];
        fr = '0;
        fr[FC-1:0] = req.frame_in[FC-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            page_match[i]  = valid_reg[i] && (page_reg[i] == pg);
            frame_match[i] = valid_reg[i] && (frame_reg[i] == fr);
            free_vec[i]    = !valid_reg[i];
        end
        // Isolate the lowest set bit so that the lowest index wins.
        page_oh  = page_match & (~page_match + NUM_ENTRIES'(1));
        frame_oh = frame_match & (~frame_match + NUM_ENTRIES'(1));
        free_oh  = free_vec & (~free_vec + NUM_ENTRIES'(1));

        hit_index    = '0;
        frame_index  = '0;
        free_index   = '0;
        hit_frame    = '0;
        hit_readonly = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (page_oh[i])
            begin
                hit_index    = hit_index | IW'(i);
                hit_frame    = hit_frame | frame_reg[i];
                hit_readonly = hit_readonly | readonly_reg[i];
            end
            if (frame_oh[i])
            begin
                frame_index = frame_index | IW'(i);
            end
            if (free_oh[i])
            begin
                free_index = free_index | IW'(i);
            end
        end
        hit = |page_match;
    end

    // Reuse the entry holding the frame, else a free entry, else the oldest one, else entry zero.
    always_comb
    begin
        if (|frame_match)
        begin
            add_index = frame_index;
            remove_en = 1'b1;
        end
        else if (|free_vec)
        begin
            add_index = free_index;
            remove_en = 1'b0;
        end
        else if (head_ok)
        begin
            add_index = head;
            remove_en = 1'b1;
        end
        else
        begin
            add_index = '0;
            remove_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            page_reg[add_index]     <= pg;
            frame_reg[add_index]    <= fr;
            readonly_reg[add_index] <= req.readonly_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (write_en)
        begin
            valid_reg[add_index] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/tlb_fifo_replacement.sv */
// Top level of the fully associative TLB with FIFO replacement.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative TLB of NUM_ENTRIES entries. A lookup request compares its page
// against all valid entries at once and returns hit, frame, read-only flag and slot;
// an add request writes the entry that already holds the frame, else the lowest free
// entry, else the oldest entry in replacement order. Each response also carries the
// running hit, miss and change counts. One request is taken every clock cycle while
// responses are not stalled. A request is held in the input register; the parallel
// compare and the queue shift then load the response register, which presents the
// response. Entry contents are not cleared by reset, only the valid bits, so the
// block takes requests right after reset.
module tlb_fifo_replacement #(
    parameter int NUM_ENTRIES = tfr_pkg::NUM_ENTRIES_DEF,
    parameter int PAGE_BITS   = tfr_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS  = tfr_pkg::FRAME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tfr_pkg::tfr_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tfr_pkg::tfr_rsp_t rsp_data
);

    import tfr_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int SC = (IW < SLOT_W) ? IW : SLOT_W;
    localparam int FC = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;

    logic                  in_valid_reg;
    tfr_req_t              req_reg;
    logic                  rsp_valid_reg;
    tfr_rsp_t              rsp_data_reg;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    miss_cnt_reg;
    logic [COUNT_W-1:0]    change_cnt_reg;
    logic [COUNT_W-1:0]    hit_cnt_next;
    logic [COUNT_W-1:0]    miss_cnt_next;
    logic [COUNT_W-1:0]    change_cnt_next;

    logic                  advance;
    logic                  proc;
    logic                  is_add;
    logic                  cam_hit;
    logic [FRAME_BITS-1:0] cam_frame;
    logic                  cam_readonly;
    logic [IW-1:0]         hit_index;
    logic [IW-1:0]         add_index;
    logic                  remove_en;
    logic [IW-1:0]         head;
    logic                  head_ok;
    tfr_rsp_t              rsp_next;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign proc      = in_valid_reg && advance;
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign is_add    = (req_reg.command == CMD_ADD);

    tfr_cam #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_cam (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_reg),
        .write_en     (proc && is_add),
        .head         (head),
        .head_ok      (head_ok),
        .hit          (cam_hit),
        .hit_frame    (cam_frame),
        .hit_readonly (cam_readonly),
        .hit_index    (hit_index),
        .add_index    (add_index),
        .remove_en    (remove_en)
    );

    tfr_fifo #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .update_en (proc && is_add),
        .remove_en (remove_en),
        .value     (add_index),
        .head      (head),
        .head_ok   (head_ok)
    );

    always_comb
    begin
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        change_cnt_next = change_cnt_reg;
        if (is_add)
        begin
            change_cnt_next = change_cnt_reg + COUNT_W'(1);
        end
        else if (cam_hit)
        begin
            hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
        end
        else
        begin
            miss_cnt_next = miss_cnt_reg + COUNT_W'(1);
        end

        rsp_next              = '0;
        rsp_next.hit_count    = hit_cnt_next;
        rsp_next.miss_count   = miss_cnt_next;
        rsp_next.change_count = change_cnt_next;
        if (is_add)
        begin
            rsp_next.slot[SC-1:0] = add_index[SC-1:0];
        end
        else if (cam_hit)
        begin
            rsp_next.hit                = 1'b1;
            rsp_next.frame_out[FC-1:0]  = cam_frame[FC-1:0];
            rsp_next.readonly_out       = cam_readonly;
            rsp_next.slot[SC-1:0]       = hit_index[SC-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req_data;
        end
        if (proc)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            change_cnt_reg <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
            if (proc)
            begin
                hit_cnt_reg    <= hit_cnt_next;
                miss_cnt_reg   <= miss_cnt_next;
                change_cnt_reg <= change_cnt_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.hit
        |-> (rsp_data.frame_out == '0) && !rsp_data.readonly_out)
        else $error("response without a hit carries frame or read-only data");

    a_proc_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> rsp_valid)
        else $error("processed request produced no response");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        proc && is_add |=> change_cnt_reg == $past(change_cnt_reg) + COUNT_W'(1))
        else $error("add request not counted as a change");
`endif

endmodule

`default_nettype wire

/* verif/tlb_fifo_replacement_tb.sv */
// Self-checking testbench for the TLB with FIFO replacement.
`timescale 1ns / 1ps

module tlb_fifo_replacement_tb;

    import tfr_pkg::*;

    localparam int ENTRIES     = NUM_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    tfr_req_t req_data = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    tfr_rsp_t rsp_data;

    // Shadow copy of the translation table and its replacement order.
    bit                 shadow_valid [ENTRIES];
    logic [PAGE_W-1:0]  shadow_page [ENTRIES];
    logic [FRAME_W-1:0] shadow_frame [ENTRIES];
    bit                 shadow_ro [ENTRIES];
    int                 age_order [$];
    logic [COUNT_W-1:0] hits_seen = '0;
    logic [COUNT_W-1:0] misses_seen = '0;
    logic [COUNT_W-1:0] adds_seen = '0;
    int                 evictions = 0;
    int                 frame_reuses = 0;

    tfr_rsp_t expected_rsp [$];
    int       mismatch_count = 0;
    int       requests_taken = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_active = 1'b0;

    tlb_fifo_replacement u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // Computes the response to one request and advances the shadow table.
    function automatic tfr_rsp_t translate_request(tfr_req_t req);
        tfr_rsp_t rsp;
        int       idx;
        int       k;
        bit       found;
        rsp = '0;
        idx = 0;
        found = 1'b0;
        if (req.command == CMD_LOOKUP)
        begin
            for (k = 0; k < ENTRIES; k++)
            begin
                if (!found && shadow_valid[k] && shadow_page[k] == req.page)
                begin
                    found = 1'b1;
                    idx = k;
                end
            end
            if (found)
            begin
                rsp.hit = 1'b1;
                rsp.frame_out = shadow_frame[idx];
                rsp.readonly_out = shadow_ro[idx];
                rsp.slot = idx[SLOT_W-1:0];
                hits_seen++;
            end
            else
            begin
                misses_seen++;
            end
        end
        else
        begin
            adds_seen++;
            for (k = 0; k < ENTRIES; k++)
            begin
                if (!found && shadow_valid[k] && shadow_frame[k] == req.frame_in)
                begin
                    found = 1'b1;
                    idx = k;
                end
            end
            if (found)
            begin
                frame_reuses++;
                for (k = 0; k < age_order.size(); k++)
                begin
                    if (age_order[k] == idx)
                    begin
                        age_order.delete(k);
                        break;
                    end
                end
            end
            for (k = 0; k < ENTRIES; k++)
            begin
                if (!found && !shadow_valid[k])
                begin
                    found = 1'b1;
                    idx = k;
                end
            end
            // With every entry taken, the oldest one in the order is replaced.
            if (!found)
            begin
                evictions++;
                idx = (age_order.size() > 0) ? age_order.pop_front() : 0;
            end
            shadow_valid[idx] = 1'b1;
            shadow_page[idx] = req.page;
            shadow_frame[idx] = req.frame_in;
            shadow_ro[idx] = req.readonly_in;
            if (age_order.size() < ENTRIES)
                age_order.push_back(idx);
            rsp.slot = idx[SLOT_W-1:0];
        end
        rsp.hit_count = hits_seen;
        rsp.miss_count = misses_seen;
        rsp.change_count = adds_seen;
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    function automatic tfr_req_t make_request(logic command, logic [PAGE_W-1:0] page,
                                              logic [FRAME_W-1:0] frame, logic ro);
        tfr_req_t req;
        req.command = command;
        req.page = page;
        req.frame_in = frame;
        req.readonly_in = ro;
        return req;
    endfunction

    // Pages come mostly, and frames half the time, from small pools so that hits, frame
    // reuse and evictions are frequent; the rest cover the whole field range.
    function automatic tfr_req_t random_request();
        tfr_req_t req;
        req.command = ($urandom_range(99) < 45) ? CMD_ADD : CMD_LOOKUP;
        req.page = ($urandom_range(99) < 75) ? PAGE_W'($urandom_range(0, 23))
                                              : PAGE_W'($urandom_range(0, 255));
        req.frame_in = ($urandom_range(99) < 50) ? FRAME_W'($urandom_range(0, 19))
                                                  : FRAME_W'($urandom_range(0, 255));
        req.readonly_in = 1'($urandom_range(0, 1));
        return req;
    endfunction

    always @(posedge clk)
    begin : monitor
        tfr_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(translate_request(req_data));
                requests_taken++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: response with none expected, actual %0h",
                                 $time, rsp_data);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("hit", COUNT_W'(want.hit), COUNT_W'(rsp_data.hit));
                    check_field("frame_out", COUNT_W'(want.frame_out),
                                COUNT_W'(rsp_data.frame_out));
                    check_field("readonly_out", COUNT_W'(want.readonly_out),
                                COUNT_W'(rsp_data.readonly_out));
                    check_field("slot", COUNT_W'(want.slot), COUNT_W'(rsp_data.slot));
                    check_field("hit_count", want.hit_count, rsp_data.hit_count);
                    check_field("miss_count", want.miss_count, rsp_data.miss_count);
                    check_field("change_count", want.change_count, rsp_data.change_count);
                end
            end
        end
    end

    always @(posedge clk)
        rsp_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tlb_fifo_replacement_tb: errors");
        $finish;
    end

    task automatic send_request(tfr_req_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= req;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int k;
        send_request(make_request(CMD_LOOKUP, 8'h00, 8'h00, 1'b0));  // empty table
        send_request(make_request(CMD_ADD, 8'hFF, 8'hFF, 1'b1));
        send_request(make_request(CMD_ADD, 8'h00, 8'h00, 1'b0));
        send_request(make_request(CMD_ADD, 8'hFF, 8'h01, 1'b0));     // same page twice
        send_request(make_request(CMD_LOOKUP, 8'hFF, 8'h00, 1'b0));  // lowest entry wins
        send_request(make_request(CMD_LOOKUP, 8'h00, 8'hA5, 1'b1));
        // Same frame again: the entry is rewritten in place and becomes newest.
        send_request(make_request(CMD_ADD, 8'h10, 8'hFF, 1'b0));
        send_request(make_request(CMD_LOOKUP, 8'hFF, 8'h00, 1'b0));
        for (k = 0; k < ENTRIES - 3; k++)
            send_request(make_request(CMD_ADD, PAGE_W'(8'h20 + k), FRAME_W'(8'h20 + k),
                                      1'(k)));
        // Table full: each new frame replaces the oldest entry.
        send_request(make_request(CMD_ADD, 8'h80, 8'h80, 1'b1));
        send_request(make_request(CMD_LOOKUP, 8'h00, 8'h00, 1'b0));
        send_request(make_request(CMD_ADD, 8'h81, 8'h81, 1'b0));
        send_request(make_request(CMD_LOOKUP, 8'h80, 8'h00, 1'b0));
    endtask

    task automatic test_random_traffic(int count, int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count)
            send_request(random_request());
    endtask

    // The receiver holds off long enough for the block to fill and stall requests.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (60)
                    @(posedge clk);
                hold_active <= 1'b0;
            end
            repeat (30)
                send_request(random_request());
        join
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(240, 38, 58);
        test_random_traffic(240, 58, 38);
        test_random_traffic(240, 0, 0);
        test_backpressure();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        $display("Covered %0d requests: %0d lookup hits, %0d misses, %0d adds.",
                 requests_taken, hits_seen, misses_seen, adds_seen);
        $display("Adds replaced %0d oldest entries and rewrote %0d by frame; %0d mismatches.",
                 evictions, frame_reuses, mismatch_count);
        if (mismatch_count == 0)
            $display("tlb_fifo_replacement_tb: clean");
        else
            $display("tlb_fifo_replacement_tb: errors");
        $finish;
    end

endmodule
